/* sv/rte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and constants of the 3-D tree extension block.
// ----------------------------------------------------------------------------
package rte_pkg;

    typedef enum logic [2:0] {
        ST_ROOT     = 3'd0,
        ST_EXTENDED = 3'd1,
        ST_GOAL     = 3'd2,
        ST_LIMIT    = 3'd3,
        ST_REFUSED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SQRT_LD,
        S_SQRT_W,
        S_STEER_LD,
        S_STEER_W,
        S_GOAL_LD,
        S_GOAL_W
    } state_t;

    localparam logic REQ_START = 1'b0;

    localparam logic [2:0] CFG_GOAL_X     = 3'd0;
    localparam logic [2:0] CFG_GOAL_Y     = 3'd1;
    localparam logic [2:0] CFG_GOAL_Z     = 3'd2;
    localparam logic [2:0] CFG_STEP       = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD  = 3'd4;
    localparam logic [2:0] CFG_ITER_LIMIT = 3'd5;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [9:0]         vertex_index;
        logic [9:0]         parent_index;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
    } res_t;

endpackage
`default_nettype wire

/* sv/rte_dist_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rte_dist_pipe
// Three-stage squared distance pipeline: magnitudes, squares, sum.
// ----------------------------------------------------------------------------
module rte_dist_pipe #(
    parameter int TW = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [TW-1:0]      in_tag,
    input  wire logic signed [31:0] ax,
    input  wire logic signed [31:0] ay,
    input  wire logic signed [31:0] az,
    input  wire logic signed [31:0] bx,
    input  wire logic signed [31:0] by,
    input  wire logic signed [31:0] bz,
    output logic                    out_valid,
    output logic [TW-1:0]           out_tag,
    output logic [67:0]             out_sum,
    output logic signed [31:0]      out_ax,
    output logic signed [31:0]      out_ay,
    output logic signed [31:0]      out_az
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [TW-1:0] t1_reg, t2_reg, t3_reg;
    logic [32:0] mx_reg, my_reg, mz_reg;
    logic [65:0] qx_reg, qy_reg, qz_reg;
    logic [67:0] sum_reg;
    logic signed [31:0] a1x_reg, a1y_reg, a1z_reg;
    logic signed [31:0] a2x_reg, a2y_reg, a2z_reg;
    logic signed [31:0] a3x_reg, a3y_reg, a3z_reg;
    logic signed [32:0] dx, dy, dz;

    assign dx = {ax[31], ax} - {bx[31], bx};
    assign dy = {ay[31], ay} - {by[31], by};
    assign dz = {az[31], az} - {bz[31], bz};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= dx[32] ? 33'(-dx) : 33'(dx);
        my_reg  <= dy[32] ? 33'(-dy) : 33'(dy);
        mz_reg  <= dz[32] ? 33'(-dz) : 33'(dz);
        t1_reg  <= in_tag;
        a1x_reg <= ax;
        a1y_reg <= ay;
        a1z_reg <= az;

        qx_reg  <= 66'(mx_reg) * 66'(mx_reg);
        qy_reg  <= 66'(my_reg) * 66'(my_reg);
        qz_reg  <= 66'(mz_reg) * 66'(mz_reg);
        t2_reg  <= t1_reg;
        a2x_reg <= a1x_reg;
        a2y_reg <= a1y_reg;
        a2z_reg <= a1z_reg;

        sum_reg <= 68'(qx_reg) + 68'(qy_reg) + 68'(qz_reg);
        t3_reg  <= t2_reg;
        a3x_reg <= a2x_reg;
        a3y_reg <= a2y_reg;
        a3z_reg <= a2z_reg;
    end

    assign out_valid = v3_reg;
    assign out_tag   = t3_reg;
    assign out_sum   = sum_reg;
    assign out_ax    = a3x_reg;
    assign out_ay    = a3y_reg;
    assign out_az    = a3z_reg;

endmodule
`default_nettype wire

/* sv/rte_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rte_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rte_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [67:0] radicand,
    output logic             done,
    output logic [33:0]      root
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [67:0] val_reg;
    logic [35:0] rem_reg;
    logic [33:0] root_reg;
    logic [35:0] rem_sh, trial;

    assign rem_sh = {rem_reg[33:0], val_reg[67:66]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd33)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[65:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[32:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[32:0], 1'b0};
            end
        end
    end

    assign done = !busy_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

/* sv/rte_steer_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rte_steer_cell
// One axis of the step: scale the offset, divide by the distance, saturate.
// ----------------------------------------------------------------------------
module rte_steer_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic signed [31:0] from,
    input  wire logic signed [31:0] to,
    input  wire logic [30:0]        step_len,
    input  wire logic [33:0]        span,
    output logic                    done,
    output logic signed [31:0]      coord
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic signed [31:0] from_reg;
    logic        neg_reg, zero_reg;
    logic [32:0] mag_reg;
    logic [33:0] dist_reg;
    logic [30:0] step_reg;
    logic [63:0] prod_reg, quo_reg;
    logic [34:0] rem_reg;
    logic [34:0] rem_sh;
    logic signed [32:0] diff;
    logic [33:0] q_lim;
    logic signed [35:0] off, sum;

    assign diff   = {to[31], to} - {from[31], from};
    assign rem_sh = {rem_reg[33:0], prod_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == 7'd64)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            from_reg <= from;
            neg_reg  <= diff[32];
            mag_reg  <= diff[32] ? 33'(-diff) : 33'(diff);
            zero_reg <= (span == '0);
            dist_reg <= span;
            step_reg <= step_len;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
            begin
                prod_reg <= 64'(step_reg) * 64'(mag_reg);
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            else
            begin
                prod_reg <= {prod_reg[62:0], 1'b0};
                if (rem_sh >= {1'b0, dist_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, dist_reg};
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        q_lim = (quo_reg > 64'h2_0000_0000) ? 34'h2_0000_0000 : quo_reg[33:0];
        off   = neg_reg ? -$signed({2'b00, q_lim}) : $signed({2'b00, q_lim});
        sum   = {{4{from_reg[31]}}, from_reg} + off;
        if (zero_reg)
        begin
            coord = from_reg;
        end
        else if (sum > 36'sd2147483647)
        begin
            coord = 32'sh7FFF_FFFF;
        end
        else if (sum < -36'sd2147483648)
        begin
            coord = 32'sh8000_0000;
        end
        else
        begin
            coord = sum[31:0];
        end
    end

    assign done = !busy_reg;

endmodule
`default_nettype wire

/* sv/rrt_tree_extend_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrt_tree_extend_top
// 3-D rapidly-exploring random tree growth over an on-chip vertex table.
// ----------------------------------------------------------------------------
// A start beat or a refused sample gives its result in the cycle after accept.
// A sample that extends shows its result after one memory read per vertex
// through the distance pipeline, the square root, the three per-axis steer
// cells working side by side, and the goal distance pass. busy stays high
// meanwhile. Each result shows for one cycle with result_valid; the
// receiver cannot stall it, so capture it on that cycle.
// ----------------------------------------------------------------------------
module rrt_tree_extend_top #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rte_pkg::req_t req,
    output logic               result_valid,
    output rte_pkg::res_t      result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic signed [31:0] mem_x [MAX_VERTICES];
    logic signed [31:0] mem_y [MAX_VERTICES];
    logic signed [31:0] mem_z [MAX_VERTICES];

    rte_pkg::state_t state_reg, state_next;

    logic signed [31:0] goal_x_reg, goal_y_reg, goal_z_reg;
    logic [30:0] step_reg, thr_lin_reg;
    logic [15:0] limit_reg;
    logic [61:0] thr_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   ext_reg, ext_next;
    logic          fin_reg, fin_next;
    logic [CW-1:0] issue_reg, issue_next;

    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic [67:0]        best_d_reg;
    logic [IW-1:0]      best_i_reg;
    logic signed [31:0] bx_reg, by_reg, bz_reg;

    logic               rd_en, rv_reg;
    logic [IW-1:0]      rd_addr, rtag_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;

    logic               we;
    logic [IW-1:0]      wa;
    logic signed [31:0] wdx, wdy, wdz;

    logic               p_valid, p_out_valid;
    logic [IW-1:0]      p_out_tag;
    logic [67:0]        p_out_sum;
    logic signed [31:0] p_ax, p_ay, p_az, p_bx, p_by, p_bz;
    logic signed [31:0] p_oax, p_oay, p_oaz;

    logic        sq_load, sq_done;
    logic [33:0] sq_root;
    logic        c_load;
    logic [2:0]  c_done;
    logic signed [31:0] nx, ny, nz;

    logic          res_valid_next, res_valid_reg;
    rte_pkg::res_t res_next, res_reg;
    logic          accept;
    logic [15:0]   ext_inc;
    logic [31:0]   idx_w, par_w;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != rte_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign ext_inc   = ext_reg + 16'd1;
    assign idx_w     = 32'(count_reg);
    assign par_w     = 32'(best_i_reg);
    assign rd_addr   = issue_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            goal_z_reg  <= '0;
            step_reg    <= 31'd65536;
            thr_lin_reg <= 31'd65536;
            limit_reg   <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rte_pkg::CFG_GOAL_X:     goal_x_reg  <= cfg_data;
                rte_pkg::CFG_GOAL_Y:     goal_y_reg  <= cfg_data;
                rte_pkg::CFG_GOAL_Z:     goal_z_reg  <= cfg_data;
                rte_pkg::CFG_STEP:       step_reg    <= cfg_data[30:0];
                rte_pkg::CFG_THRESHOLD:  thr_lin_reg <= cfg_data[30:0];
                rte_pkg::CFG_ITER_LIMIT: limit_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        thr_reg <= 62'(thr_lin_reg) * 62'(thr_lin_reg);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_x[wa] <= wdx;
            mem_y[wa] <= wdy;
            mem_z[wa] <= wdz;
        end
        if (rd_en)
        begin
            rx_reg   <= mem_x[rd_addr];
            ry_reg   <= mem_y[rd_addr];
            rz_reg   <= mem_z[rd_addr];
            rtag_reg <= rd_addr;
        end
    end

    always_comb
    begin
        if (state_reg == rte_pkg::S_SCAN)
        begin
            p_valid = rv_reg;
            p_ax = rx_reg;
            p_ay = ry_reg;
            p_az = rz_reg;
            p_bx = sx_reg;
            p_by = sy_reg;
            p_bz = sz_reg;
        end
        else
        begin
            p_valid = (state_reg == rte_pkg::S_GOAL_LD);
            p_ax = nx;
            p_ay = ny;
            p_az = nz;
            p_bx = goal_x_reg;
            p_by = goal_y_reg;
            p_bz = goal_z_reg;
        end
    end

    rte_dist_pipe #(
        .TW (IW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_tag    (rtag_reg),
        .ax        (p_ax),
        .ay        (p_ay),
        .az        (p_az),
        .bx        (p_bx),
        .by        (p_by),
        .bz        (p_bz),
        .out_valid (p_out_valid),
        .out_tag   (p_out_tag),
        .out_sum   (p_out_sum),
        .out_ax    (p_oax),
        .out_ay    (p_oay),
        .out_az    (p_oaz)
    );

    rte_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (sq_load),
        .radicand (best_d_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    rte_steer_cell u_cell_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (c_load),
        .from     (bx_reg),
        .to       (sx_reg),
        .step_len (step_reg),
        .span     (sq_root),
        .done     (c_done[0]),
        .coord    (nx)
    );

    rte_steer_cell u_cell_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (c_load),
        .from     (by_reg),
        .to       (sy_reg),
        .step_len (step_reg),
        .span     (sq_root),
        .done     (c_done[1]),
        .coord    (ny)
    );

    rte_steer_cell u_cell_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (c_load),
        .from     (bz_reg),
        .to       (sz_reg),
        .step_len (step_reg),
        .span     (sq_root),
        .done     (c_done[2]),
        .coord    (nz)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= req.coord_x;
            sy_reg <= req.coord_y;
            sz_reg <= req.coord_z;
        end
        if ((state_reg == rte_pkg::S_SCAN) && p_out_valid &&
            ((p_out_tag == '0) || (p_out_sum < best_d_reg)))
        begin
            best_d_reg <= p_out_sum;
            best_i_reg <= p_out_tag;
            bx_reg     <= p_oax;
            by_reg     <= p_oay;
            bz_reg     <= p_oaz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rte_pkg::S_IDLE;
            count_reg     <= '0;
            ext_reg       <= '0;
            fin_reg       <= 1'b1;
            issue_reg     <= '0;
            rv_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ext_reg       <= ext_next;
            fin_reg       <= fin_next;
            issue_reg     <= issue_next;
            rv_reg        <= rd_en;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid_next)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ext_next       = ext_reg;
        fin_next       = fin_reg;
        issue_next     = issue_reg;
        rd_en          = 1'b0;
        sq_load        = 1'b0;
        c_load         = 1'b0;
        we             = 1'b0;
        wa             = '0;
        wdx            = nx;
        wdy            = ny;
        wdz            = nz;
        res_valid_next = 1'b0;
        res_next       = '0;

        unique case (state_reg)
            rte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next = 1'b1;
                    if (req.req_type == rte_pkg::REQ_START)
                    begin
                        we               = 1'b1;
                        wdx              = req.coord_x;
                        wdy              = req.coord_y;
                        wdz              = req.coord_z;
                        count_next       = CW'(1);
                        ext_next         = '0;
                        fin_next         = 1'b0;
                        res_next.status  = rte_pkg::ST_ROOT;
                        res_next.new_x   = req.coord_x;
                        res_next.new_y   = req.coord_y;
                        res_next.new_z   = req.coord_z;
                    end
                    else if (fin_reg || (count_reg == '0) ||
                             (count_reg >= CW'(MAX_VERTICES)))
                    begin
                        res_next.status = rte_pkg::ST_REFUSED;
                    end
                    else
                    begin
                        res_valid_next = 1'b0;
                        issue_next     = '0;
                        state_next     = rte_pkg::S_SCAN;
                    end
                end
            end
            rte_pkg::S_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
                if (p_out_valid && (CW'(p_out_tag) == count_reg - CW'(1)))
                begin
                    state_next = rte_pkg::S_SQRT_LD;
                end
            end
            rte_pkg::S_SQRT_LD:
            begin
                sq_load    = 1'b1;
                state_next = rte_pkg::S_SQRT_W;
            end
            rte_pkg::S_SQRT_W:
            begin
                if (sq_done)
                begin
                    state_next = rte_pkg::S_STEER_LD;
                end
            end
            rte_pkg::S_STEER_LD:
            begin
                c_load     = 1'b1;
                state_next = rte_pkg::S_STEER_W;
            end
            rte_pkg::S_STEER_W:
            begin
                if (&c_done)
                begin
                    state_next = rte_pkg::S_GOAL_LD;
                end
            end
            rte_pkg::S_GOAL_LD:
            begin
                we         = 1'b1;
                wa         = count_reg[IW-1:0];
                state_next = rte_pkg::S_GOAL_W;
            end
            rte_pkg::S_GOAL_W:
            begin
                if (p_out_valid)
                begin
                    res_valid_next        = 1'b1;
                    res_next.vertex_index = idx_w[9:0];
                    res_next.parent_index = par_w[9:0];
                    res_next.new_x        = nx;
                    res_next.new_y        = ny;
                    res_next.new_z        = nz;
                    count_next            = count_reg + CW'(1);
                    ext_next              = ext_inc;
                    if (p_out_sum < 68'(thr_reg))
                    begin
                        res_next.status = rte_pkg::ST_GOAL;
                        fin_next        = 1'b1;
                    end
                    else if (ext_inc >= limit_reg)
                    begin
                        res_next.status = rte_pkg::ST_LIMIT;
                        fin_next        = 1'b1;
                    end
                    else
                    begin
                        res_next.status = rte_pkg::ST_EXTENDED;
                    end
                    if (count_reg + CW'(1) >= CW'(MAX_VERTICES))
                    begin
                        fin_next = 1'b1;
                    end
                    state_next = rte_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rte_pkg::S_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire
